[sv/shs_pkg.sv]
// ----------------------------------------------------------------------------
// shs_pkg
// Shared constants, types and functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 61;
    localparam int VB_W    = 3;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int ROUND_W = 6;

    localparam logic [SLOT_W-1:0]  LAST_SLOT    = 4'd15;
    localparam logic [SLOT_W-1:0]  LEN_HI_SLOT  = 4'd14;
    localparam logic [ROUND_W-1:0] LAST_ROUND   = 6'd63;
    localparam logic [IDX_W-1:0]   LAST_IDX     = 3'd7;
    localparam logic [VB_W-1:0]    FULL_BYTES   = 3'd4;
    localparam logic [WORD_W-1:0]  MARKER_WORD  = 32'h8000_0000;

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic update;
    } rnd_ctrl_t;

    typedef struct packed {
        logic push;
        logic expand;
    } sch_ctrl_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // keep the leading valid bytes; below four bytes, place the 0x80 marker right after them
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] word,
                                                   input logic [VB_W-1:0] nbytes);
        case (nbytes)
            3'd0:    pad_word = 32'h8000_0000;
            3'd1:    pad_word = {word[31:24], 24'h80_0000};
            3'd2:    pad_word = {word[31:16], 16'h8000};
            3'd3:    pad_word = {word[31:8], 8'h80};
            default: pad_word = word;
        endcase
    endfunction

endpackage

[sv/shs_sched.sv]
// ----------------------------------------------------------------------------
// shs_sched
// Block buffer and message schedule: a 16-word shift line that takes message
// words in and expands W[t] one word per round.
// ----------------------------------------------------------------------------
module shs_sched (
    input  logic                          clk,
    input  shs_pkg::sch_ctrl_t            ctrl,
    input  logic [shs_pkg::WORD_W-1:0]    push_data,
    output logic [shs_pkg::WORD_W-1:0]    w_word
);

    logic [shs_pkg::WORD_W-1:0] w_reg [16];
    logic [shs_pkg::WORD_W-1:0] w_new;

    always_comb
    begin
        w_new = w_reg[0] + shs_pkg::small_sigma0(w_reg[1]) + w_reg[9]
              + shs_pkg::small_sigma1(w_reg[14]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.expand)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= ctrl.push ? push_data : w_new;
        end
    end

    assign w_word = w_reg[0];

endmodule

[sv/shs_round.sv]
// ----------------------------------------------------------------------------
// shs_round
// Chaining hash, working variables and the shared compression round unit.
// ----------------------------------------------------------------------------
module shs_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shs_pkg::rnd_ctrl_t            ctrl,
    input  logic [shs_pkg::ROUND_W-1:0]   round_idx,
    input  logic [shs_pkg::WORD_W-1:0]    w_word,
    input  logic [shs_pkg::IDX_W-1:0]     digest_idx,
    output logic [shs_pkg::WORD_W-1:0]    digest_word
);

    logic [shs_pkg::WORD_W-1:0] chain_reg [8];
    logic [shs_pkg::WORD_W-1:0] var_reg   [8];
    logic [shs_pkg::WORD_W-1:0] t1;
    logic [shs_pkg::WORD_W-1:0] t2;

    always_comb
    begin
        t1 = var_reg[7] + shs_pkg::big_sigma1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + shs_pkg::ROUND_K[round_idx] + w_word;
        t2 = shs_pkg::big_sigma0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shs_pkg::INIT_HASH[i];
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shs_pkg::INIT_HASH[i];
            end
        end
        else if (ctrl.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + var_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = chain_reg[digest_idx];

endmodule

[sv/sha256_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 of a word stream: one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Input channel s_axis: one big-endian message word per transfer with its
// count of valid leading bytes; tlast marks the last word of the message (an
// empty message is a single tlast transfer with zero bytes).
// Output channel m_axis: the eight digest words H0..H7, tlast on the eighth.
// A word that closes a 16-word block starts 64 rounds through the single
// round unit and one chaining update, with s_axis_tready low. The last word
// adds padding pushes (one per cycle while no compression runs) and one or
// two compressions, then the digest is offered one word per cycle while
// m_axis_tready is high. While the digest is offered no input is taken; a
// stall on m_axis_tready holds the current digest word. After the eighth
// transfer the block starts a new message. Reset loads the initial hash
// values and clears the count.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic        s_axis_tlast,   // final_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index
    output logic        m_axis_tlast    // digest_last
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t                             state_reg, state_next;
    logic [shs_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [shs_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [shs_pkg::ROUND_W-1:0]        round_reg, round_next;
    logic [shs_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic                               pad_active_reg, pad_active_next;
    logic                               marker_done_reg, marker_done_next;
    logic                               len_hi_done_reg, len_hi_done_next;
    logic                               pad_done_reg, pad_done_next;

    shs_pkg::rnd_ctrl_t                 rctl;
    shs_pkg::sch_ctrl_t                 sctl;
    logic [shs_pkg::WORD_W-1:0]         push_data;
    logic [shs_pkg::WORD_W-1:0]         w_word;
    logic [shs_pkg::WORD_W-1:0]         digest_word;
    logic [shs_pkg::WORD_W-1:0]         in_word;
    logic [shs_pkg::VB_W-1:0]           in_bytes;

    assign in_word  = s_axis_tdata[31:0];
    assign in_bytes = (s_axis_tdata[34:32] > shs_pkg::FULL_BYTES) ? shs_pkg::FULL_BYTES
                                                                 : s_axis_tdata[34:32];

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        slot_next        = slot_reg;
        round_next       = round_reg;
        idx_next         = idx_reg;
        pad_active_next  = pad_active_reg;
        marker_done_next = marker_done_reg;
        len_hi_done_next = len_hi_done_reg;
        pad_done_next    = pad_done_reg;
        rctl             = '0;
        sctl             = '0;
        push_data        = '0;
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    sctl.push = 1'b1;
                    slot_next = slot_reg + 1'b1;
                    if (!s_axis_tlast)
                    begin
                        push_data  = in_word;
                        count_next = count_reg + shs_pkg::COUNT_W'(shs_pkg::FULL_BYTES);
                        if (slot_reg == shs_pkg::LAST_SLOT)
                        begin
                            rctl.load  = 1'b1;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        count_next      = count_reg + shs_pkg::COUNT_W'(in_bytes);
                        pad_active_next = 1'b1;
                        push_data       = shs_pkg::pad_word(in_word, in_bytes);
                        marker_done_next = (in_bytes != shs_pkg::FULL_BYTES);
                        if (slot_reg == shs_pkg::LAST_SLOT)
                        begin
                            rctl.load  = 1'b1;
                            state_next = ST_ROUND;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                rctl.step   = 1'b1;
                sctl.expand = 1'b1;
                round_next  = round_reg + 1'b1;
                if (round_reg == shs_pkg::LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                rctl.update = 1'b1;
                if (pad_done_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                sctl.push = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (!marker_done_reg)
                begin
                    push_data        = shs_pkg::MARKER_WORD;
                    marker_done_next = 1'b1;
                end
                else if (len_hi_done_reg)
                begin
                    push_data     = {count_reg[28:0], 3'b000};
                    pad_done_next = 1'b1;
                end
                else if (slot_reg == shs_pkg::LEN_HI_SLOT)
                begin
                    push_data        = count_reg[60:29];
                    len_hi_done_next = 1'b1;
                end
                else
                begin
                    push_data = '0;
                end
                if (slot_reg == shs_pkg::LAST_SLOT)
                begin
                    rctl.load  = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (idx_reg == shs_pkg::LAST_IDX)
                    begin
                        rctl.init        = 1'b1;
                        count_next       = '0;
                        slot_next        = '0;
                        pad_active_next  = 1'b0;
                        marker_done_next = 1'b0;
                        len_hi_done_next = 1'b0;
                        pad_done_next    = 1'b0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            slot_reg        <= '0;
            round_reg       <= '0;
            idx_reg         <= '0;
            pad_active_reg  <= 1'b0;
            marker_done_reg <= 1'b0;
            len_hi_done_reg <= 1'b0;
            pad_done_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            slot_reg        <= slot_next;
            round_reg       <= round_next;
            idx_reg         <= idx_next;
            pad_active_reg  <= pad_active_next;
            marker_done_reg <= marker_done_next;
            len_hi_done_reg <= len_hi_done_next;
            pad_done_reg    <= pad_done_next;
        end
    end

    shs_sched u_sched (
        .clk       (clk),
        .ctrl      (sctl),
        .push_data (push_data),
        .w_word    (w_word)
    );

    shs_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (rctl),
        .round_idx   (round_reg),
        .w_word      (w_word),
        .digest_idx  (idx_reg),
        .digest_word (digest_word)
    );

    assign m_axis_tdata = {5'b00000, idx_reg, digest_word};
    assign m_axis_tlast = (idx_reg == shs_pkg::LAST_IDX);

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for sha256_stream_hasher_core. A short table of directed words
// (empty message, "abc", byte counts out of range, short words that are not
// last) is followed by random messages of lengths around the block and
// padding boundaries. A SHA-256 model in the bench predicts the eight digest
// words of each message; every digest transfer is checked against the oldest
// prediction. Both channels stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [shs_pkg::WORD_W-1:0] word;
        logic [shs_pkg::IDX_W-1:0]  idx;
        logic                       last;
    } digest_beat_t;

    typedef struct packed {
        logic [shs_pkg::WORD_W-1:0] word;
        logic [shs_pkg::VB_W-1:0]   nbytes;
        logic                       fin;
        logic                       typed;
        logic [255:0]               digest;
    } stim_row_t;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam int DIRECTED_ROWS = 18;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'hffffffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{32'h616263ff, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
        '{32'h61626364, 3'd4, 1'b1, 1'b0, 256'd0},
        '{32'h00000000, 3'd7, 1'b1, 1'b0, 256'd0},
        '{32'hffffffff, 3'd0, 1'b0, 1'b0, 256'd0},
        '{32'h12345678, 3'd5, 1'b0, 1'b0, 256'd0},
        '{32'h9abcdef0, 3'd2, 1'b0, 1'b0, 256'd0},
        '{32'hffffffff, 3'd1, 1'b1, 1'b0, 256'd0},
        '{32'h00000000, 3'd4, 1'b0, 1'b0, 256'd0},
        '{32'hffffffff, 3'd4, 1'b0, 1'b0, 256'd0},
        '{32'h80000000, 3'd6, 1'b1, 1'b0, 256'd0},
        '{32'ha5a5a5a5, 3'd3, 1'b0, 1'b0, 256'd0},
        '{32'h5a5a5a5a, 3'd2, 1'b1, 1'b0, 256'd0},
        '{32'h00000001, 3'd5, 1'b1, 1'b0, 256'd0},
        '{32'hdeadbeef, 3'd1, 1'b0, 1'b0, 256'd0},
        '{32'h0badf00d, 3'd6, 1'b0, 1'b0, 256'd0},
        '{32'h7fffffff, 3'd7, 1'b0, 1'b0, 256'd0},
        '{32'hfffffffe, 3'd3, 1'b1, 1'b0, 256'd0}
    };

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int ITEMS_PER_PHASE = 140;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] hash_state [8];
    logic [31:0] block_words [16];
    logic [60:0] msg_bytes;
    logic [3:0]  fill;
    logic [31:0] next_digest [8];

    digest_beat_t pending_digest [$];
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           items_sent = 0;
    int           error_count = 0;

    sha256_stream_hasher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic void restart_message();
        for (int j = 0; j < 8; j++)
            hash_state[j] = HASH_IV[j];
        msg_bytes = '0;
        fill = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = block_words[j];
        for (int j = 16; j < 64; j++)
        begin
            s0 = ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3);
            s1 = ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = w[j-16] + s0 + w[j-7] + s1;
        end
        for (int j = 0; j < 8; j++)
            v[j] = hash_state[j];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_state[j] = hash_state[j] + v[j];
    endfunction

    function automatic void absorb_word(input logic [31:0] word);
        block_words[fill] = word;
        fill = fill + 4'd1;
        if (fill == 4'd0)
            compress_block();
    endfunction

    // returns 1 when the word closes a message; the digest is left in next_digest
    function automatic bit hash_item(input logic [31:0] word, input logic [2:0] nb,
                                     input logic fin);
        int          nbytes;
        logic [31:0] keep;
        logic [63:0] bitlen;
        nbytes = (nb > 3'd4) ? 4 : int'(nb);
        if (!fin)
        begin
            msg_bytes = msg_bytes + 61'd4;
            absorb_word(word);
            return 1'b0;
        end
        msg_bytes = msg_bytes + 61'(nbytes);
        if (nbytes == 4)
        begin
            absorb_word(word);
            absorb_word(32'h8000_0000);
        end
        else
        begin
            keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
            absorb_word((word & keep) | (32'h80 << (24 - 8 * nbytes)));
        end
        if (fill > 4'd14)
            while (fill != 4'd0)
                absorb_word(32'h0);
        while (fill < 4'd14)
            absorb_word(32'h0);
        bitlen = {msg_bytes, 3'b000};
        absorb_word(bitlen[63:32]);
        absorb_word(bitlen[31:0]);
        for (int j = 0; j < 8; j++)
            next_digest[j] = hash_state[j];
        restart_message();
        return 1'b1;
    endfunction

    task automatic send_word(input logic [31:0] word, input logic [2:0] nb, input logic fin,
                             input logic typed, input logic [255:0] typed_digest);
        digest_beat_t beat;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, nb, word};
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (hash_item(word, nb, fin))
        begin
            for (int j = 0; j < 8; j++)
            begin
                beat.word = typed ? typed_digest[255 - 32 * j -: 32] : next_digest[j];
                beat.idx  = j[shs_pkg::IDX_W-1:0];
                beat.last = (j == 7);
                pending_digest.push_back(beat);
            end
        end
    endtask

    task automatic send_message();
        int          roll;
        int          len;
        logic [2:0]  nb;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            len = $urandom_range(0, 16);
        else if (roll < 95)
            len = $urandom_range(13, 33);
        else
            len = $urandom_range(34, 48);
        for (int k = 0; k < len; k++)
        begin
            nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                             : shs_pkg::FULL_BYTES;
            send_word($urandom(), nb, 1'b0, 1'b0, '0);
        end
        send_word($urandom(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
    endtask

    task automatic drain_digests();
        while (pending_digest.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : digest_monitor
        digest_beat_t want;
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digest.size() == 0)
            begin
                $error("digest transfer with nothing pending: digest_word %h",
                       m_axis_tdata[31:0]);
                error_count++;
            end
            else
            begin
                want = pending_digest.pop_front();
                if (m_axis_tdata[31:0] !== want.word)
                begin
                    $error("digest_word expected %h actual %h", want.word, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[34:32] !== want.idx)
                begin
                    $error("digest_index expected %0d actual %0d", want.idx,
                           m_axis_tdata[34:32]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("digest_last expected %0b actual %0b", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        restart_message();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 28;
        rx_idle_pct = 71;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].nbytes, DIRECTED[i].fin,
                      DIRECTED[i].typed, DIRECTED[i].digest);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 71 : 0;
            rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 28 : 0;
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
                send_message();
            // hold input until every digest of this phase is out
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            drain_digests();
        end

        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sha256_stream_hasher_core.f]
sv/shs_pkg.sv
sv/shs_sched.sv
sv/shs_round.sv
sv/sha256_stream_hasher_core.sv
tb/tb.sv
